@@ sv/assert_macros.svh @@
// Assertion shorthands used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold on every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// ante at one edge implies cons at the same edge
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante at one edge implies cons at the next edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/gvn_pkg.sv @@
package gvn_pkg;

    localparam int USAGE_W = 20;
    localparam int LOOP_W  = 24;
    localparam int REQ_W   = 16;
    localparam int DIV_W   = 3;
    localparam int WC_W    = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [WC_W-1:0] WC_MAX = '1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MANUAL    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POINTS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TASK = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAISE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOM      = 3'd5;

    // register reset values
    localparam logic [9:0]  POINTS_RESET    = 10'd100;
    localparam logic [23:0] LONG_TASK_RESET = 24'd10000;
    localparam logic [9:0]  RAISE_RESET     = 10'd900;
    localparam logic [9:0]  LOWER_RESET     = 10'd850;
    localparam logic [5:0]  ROOM_RESET      = 6'd25;

    localparam logic [DIV_W-1:0] DIV_1 = 3'd1;
    localparam logic [DIV_W-1:0] DIV_2 = 3'd2;
    localparam logic [DIV_W-1:0] DIV_4 = 3'd4;

    typedef enum logic [1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_DIV    = 2'd1,
        MODE_MAX    = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_MAX  = 2'd1,
        ACT_UP   = 2'd2,
        ACT_DOWN = 2'd3
    } action_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic [USAGE_W-1:0] usage_us;
        logic [LOOP_W-1:0]  main_loop_us;
        logic [REQ_W-1:0]   divider_request;
    } in_item_t;

    typedef struct packed {
        logic [3:0] ahb_code;
        logic [2:0] apb1_code;
        logic [2:0] apb2_code;
        logic [2:0] flash_wait_states;
    } clk_codes_t;

    typedef struct packed {
        logic [1:0]       action;
        logic [DIV_W-1:0] divider;
        logic             divider_changed;
        clk_codes_t       codes;
    } result_t;

    // prescaler and flash latency for a divider
    function automatic clk_codes_t div_codes(input logic [DIV_W-1:0] div);
        clk_codes_t c;
        case (div)
            DIV_4:   c = '{ahb_code: 4'b1001, apb1_code: 3'b100, apb2_code: 3'b101,
                           flash_wait_states: 3'd1};
            DIV_2:   c = '{ahb_code: 4'b1000, apb1_code: 3'b101, apb2_code: 3'b110,
                           flash_wait_states: 3'd3};
            default: c = '{ahb_code: 4'b0000, apb1_code: 3'b110, apb2_code: 3'b111,
                           flash_wait_states: 3'd7};
        endcase
        return c;
    endfunction

endpackage

@@ sv/gvn_in_stage.sv @@
module gvn_in_stage
    import gvn_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    input  logic     down_free,
    output logic     take,
    output in_item_t item
);

    logic     valid_reg;
    in_item_t item_reg;

    assign take     = valid_reg && down_free;
    assign in_ready = !valid_reg || down_free;
    assign item     = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

@@ sv/gvn_core.sv @@
module gvn_core
    import gvn_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  take,
    input  in_item_t              item,
    output result_t               result
);

    // configuration
    logic        manual_reg;
    logic [9:0]  points_reg;
    logic [9:0]  points_next;
    logic [23:0] long_task_reg;
    logic [9:0]  raise_reg;
    logic [9:0]  lower_reg;
    logic [5:0]  room_reg;

    // governor state
    logic [DIV_W-1:0]   div_reg,  div_next;
    logic               skip_reg, skip_next;
    logic [USAGE_W-1:0] peak_reg, peak_next;
    logic [WC_W-1:0]    wc_reg,   wc_next;

    logic [WC_W-1:0]    wc_inc;
    logic               new_peak;
    logic [USAGE_W-1:0] peak_s;
    logic [WC_W-1:0]    wc_s;
    logic [8:0]         room;
    logic [USAGE_W:0]   load;
    logic               raise_hit;
    logic               low_hit;
    logic               window_full;
    logic               long_hit;
    logic [DIV_W-1:0]   req_div;
    logic [1:0]         action;
    logic               changed;

    assign wc_inc   = (wc_reg == WC_MAX) ? wc_reg : wc_reg + 1'b1;
    assign new_peak = item.usage_us > peak_reg;
    assign peak_s   = new_peak ? item.usage_us : peak_reg;
    assign wc_s     = new_peak ? '0 : wc_inc;

    // peak > raise - room  <=>  peak + room > raise (no underflow)
    assign room      = {3'b0, room_reg} * {6'b0, div_reg};
    assign load      = {1'b0, peak_s} + (USAGE_W + 1)'(room);
    assign raise_hit = load > (USAGE_W + 1)'(raise_reg);
    assign low_hit   = {load, 1'b0} < (USAGE_W + 2)'(lower_reg);
    assign window_full = wc_s >= points_reg;
    assign long_hit    = item.main_loop_us > long_task_reg;

    always_comb
    begin
        if (item.divider_request >= REQ_W'(4))
            req_div = DIV_4;
        else if (item.divider_request >= REQ_W'(2))
            req_div = DIV_2;
        else
            req_div = DIV_1;
    end

    always_comb
    begin
        div_next    = div_reg;
        skip_next   = skip_reg;
        peak_next   = peak_reg;
        wc_next     = wc_reg;
        points_next = points_reg;
        action      = ACT_NONE;
        changed     = 1'b0;
        case (item.mode)
            MODE_SAMPLE:
            begin
                if (!manual_reg)
                begin
                    if (skip_reg)
                    begin
                        skip_next = 1'b0;
                    end
                    else
                    begin
                        peak_next = peak_s;
                        wc_next   = wc_s;
                        if (long_hit)
                            action = ACT_MAX;
                        else if (raise_hit)
                            action = ACT_UP;
                        else if (window_full && low_hit)
                            action = ACT_DOWN;
                        if (window_full)
                        begin
                            peak_next = '0;
                            wc_next   = '0;
                        end
                    end
                end
            end
            MODE_DIV:
            begin
                if (req_div != div_reg)
                begin
                    div_next  = req_div;
                    skip_next = 1'b1;
                    peak_next = '0;
                    wc_next   = '0;
                    changed   = 1'b1;
                end
            end
            MODE_MAX:
            begin
                if (!manual_reg)
                begin
                    peak_next   = '0;
                    wc_next     = '0;
                    points_next = POINTS_RESET;
                    action      = ACT_MAX;
                end
            end
            default:
            begin
            end
        endcase
        result.action          = action;
        result.divider         = div_next;
        result.divider_changed = changed;
        result.codes           = div_codes(div_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_reg  <= DIV_1;
            skip_reg <= 1'b0;
            peak_reg <= '0;
            wc_reg   <= '0;
        end
        else if (take)
        begin
            div_reg  <= div_next;
            skip_reg <= skip_next;
            peak_reg <= peak_next;
            wc_reg   <= wc_next;
        end
    end

    // register writes must only come while no transaction is in flight; the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            manual_reg    <= 1'b1;
            points_reg    <= POINTS_RESET;
            long_task_reg <= LONG_TASK_RESET;
            raise_reg     <= RAISE_RESET;
            lower_reg     <= LOWER_RESET;
            room_reg      <= ROOM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MANUAL:    manual_reg    <= cfg_data[0];
                CFG_POINTS:    points_reg    <= cfg_data[9:0];
                CFG_LONG_TASK: long_task_reg <= cfg_data[23:0];
                CFG_RAISE:     raise_reg     <= cfg_data[9:0];
                CFG_LOWER:     lower_reg     <= cfg_data[9:0];
                CFG_ROOM:      room_reg      <= cfg_data[5:0];
                default:
                begin
                end
            endcase
        end
        else if (take)
        begin
            points_reg <= points_next;
        end
    end

endmodule

@@ sv/gvn_out_stage.sv @@
module gvn_out_stage
    import gvn_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    take,
    input  result_t result,
    output logic    down_free,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    logic    valid_reg;
    result_t result_reg;

    assign down_free  = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (down_free)
        begin
            valid_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= result;
        end
    end

endmodule

@@ sv/cpu_clock_divider_governor.sv @@
// Channel   Dir  tdata (low bit up)                                    tuser
// s_axis    in   usage_us[19:0] main_loop_us[43:20] divider_request    mode[1:0]
//                [59:44], zero pad to 64
// m_axis    out  action[1:0] divider[4:2] divider_changed[5] ahb_code  -
//                [9:6] apb1_code[12:10] apb2_code[15:13]
//                flash_wait_states[18:16], zero pad to 24
// cfg       in   cfg_we, cfg_index (register number), cfg_data         -
//
// One transaction per cycle sustained while m_axis is not stalled; each item passes
// from s_axis to m_axis through the input register, then the result register.
// rst_n is asynchronous; after reset the divider is 1, manual mode is on and
// all stats are cleared.
// When m_axis stalls, the result register and the input register fill, then
// s_axis_tready drops; nothing is lost.
module cpu_clock_divider_governor
    import gvn_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [63:0]           s_axis_tdata,  // usage_us, main_loop_us, divider_request
    input  logic [1:0]            s_axis_tuser,  // mode
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [23:0]           m_axis_tdata,  // action, divider, divider_changed,
                                                 // ahb_code, apb1_code, apb2_code,
                                                 // flash_wait_states
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    in_item_t in_item;
    in_item_t item;
    result_t  result;
    result_t  out_result;
    logic     take;
    logic     down_free;

    assign in_item.mode            = s_axis_tuser;
    assign in_item.usage_us        = s_axis_tdata[19:0];
    assign in_item.main_loop_us    = s_axis_tdata[43:20];
    assign in_item.divider_request = s_axis_tdata[59:44];

    gvn_in_stage u_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (in_item),
        .down_free (down_free),
        .take      (take),
        .item      (item)
    );

    gvn_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .take      (take),
        .item      (item),
        .result    (result)
    );

    gvn_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .result     (result),
        .down_free  (down_free),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (out_result)
    );

    assign m_axis_tdata = {5'b0,
                           out_result.codes.flash_wait_states,
                           out_result.codes.apb2_code,
                           out_result.codes.apb1_code,
                           out_result.codes.ahb_code,
                           out_result.divider_changed,
                           out_result.divider,
                           out_result.action};

endmodule

@@ sv/gvn_checker.sv @@
`include "assert_macros.svh"

module gvn_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    logic [1:0] action;
    logic [2:0] divider;
    logic       changed;
    logic [3:0] ahb;
    logic [2:0] ws;

    assign action  = m_axis_tdata[1:0];
    assign divider = m_axis_tdata[4:2];
    assign changed = m_axis_tdata[5];
    assign ahb     = m_axis_tdata[9:6];
    assign ws      = m_axis_tdata[18:16];

    // a stalled result holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    `ASSERT_IMPL(a_div_legal, clk, rst_n, m_axis_tvalid,
        divider == 3'd1 || divider == 3'd2 || divider == 3'd4, "illegal divider")

    // a divider change never comes with a governor action
    `ASSERT_IMPL(a_change_quiet, clk, rst_n, m_axis_tvalid && changed,
        action == 2'd0, "action reported with divider change")

    // codes follow the divider (checked for divider 4)
    `ASSERT_IMPL(a_codes, clk, rst_n, m_axis_tvalid && divider == 3'd4,
        ahb == 4'b1001 && ws == 3'd1, "codes do not match divider 4")

endmodule

bind cpu_clock_divider_governor gvn_checker u_gvn_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
